// ----- src/ism_pkg.sv -----
// Shared types, widths and codes of the interval subscription matcher.
`default_nettype none

package ism_pkg;

  localparam int unsigned MAX_SUBS        = 1024;
  localparam int unsigned MAX_CONSTRAINTS = 8;
  localparam int unsigned MAX_PAIRS       = 16;

  localparam int unsigned SUB_W   = $clog2(MAX_SUBS);          // subscription index
  localparam int unsigned NSUB_W  = $clog2(MAX_SUBS + 1);      // subscription count
  localparam int unsigned SLOT_W  = $clog2(MAX_CONSTRAINTS);   // constraint index
  localparam int unsigned CNT_W   = 4;                         // stored constraint count
  localparam int unsigned PIDX_W  = $clog2(MAX_PAIRS);         // pair buffer index
  localparam int unsigned HELD_W  = $clog2(MAX_PAIRS + 1);     // pair buffer fill
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ENTRY_W = SUB_W + SLOT_W;            // constraint table address

  localparam logic [NSUB_W-1:0] MAX_SUBS_N        = NSUB_W'(MAX_SUBS);
  localparam logic [CNT_W-1:0]  MAX_CONSTRAINTS_N = CNT_W'(MAX_CONSTRAINTS);
  localparam logic [HELD_W-1:0] MAX_PAIRS_N       = HELD_W'(MAX_PAIRS);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PAIR = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUB_RD,
    ST_SUB_CHK,
    ST_CON_RD,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // One interval constraint as held in the constraint table.
  typedef struct packed {
    logic        [ATTR_W-1:0] attribute;
    logic signed [VAL_W-1:0]  low_value;
    logic signed [VAL_W-1:0]  high_value;
  } constraint_t;

  // One buffered publication pair.
  typedef struct packed {
    logic        [ATTR_W-1:0] attribute;
    logic signed [VAL_W-1:0]  value;
  } pair_t;

endpackage

`default_nettype wire

// ----- src/ism_range_cmp.sv -----
// Shared compare unit: tests one publication pair against one interval constraint.
`default_nettype none

module ism_range_cmp (
  input  ism_pkg::constraint_t entry_i,
  input  ism_pkg::pair_t       pair_i,
  output logic                 hit_o
);

  logic attr_eq;
  logic above_low;
  logic below_high;

  assign attr_eq    = (pair_i.attribute == entry_i.attribute);
  assign above_low  = (pair_i.value >= entry_i.low_value);
  assign below_high = (pair_i.value <= entry_i.high_value);

  // An empty interval (low above high) can never satisfy both bounds.
  assign hit_o = attr_eq & above_low & below_high;

endmodule

`default_nettype wire

// ----- src/interval_subscription_matcher_top.sv -----
// Top level of the interval subscription matcher: sequencer, tables and pair buffer.
//
// Usage. Items arrive on the input channel (in_valid_i / in_stall_o); a transfer
// happens at a clock edge with valid high and stall low. A constraint load
// (cmd 0) writes one (attribute, low, high) entry of a subscription; the load
// flagged last also sets that subscription's constraint count. A publication
// pair (cmd 1) goes into a 16-entry pair buffer; pairs past that are dropped
// and remembered. The pair flagged last starts the match and yields exactly
// one result transfer on the output channel (out_valid_o / out_stall_i).
// Loads and non-final pairs are taken back to back while the block is idle.
// A match walks the subscriptions one at a time through one shared compare
// unit: per subscription a count read and a check, then per constraint visited
// a table read and a scan that tests the buffered pairs one at a time, with one
// step more when no held pair meets it, and last the load of the result. The
// pair scan sets the rate. The input is stalled for the whole match. A finished
// result sits in an output register; if the receiver stalls, the next items are
// still taken and only a following match waits for the register to empty.
// Reset: the constraint count table is cleared by a pass over its 1024 entries
// with the input stalled; configuration writes are accepted at any time and the
// register subscriptions_in_use resets to zero.
`default_nettype none

module interval_subscription_matcher_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration register subscriptions_in_use
  input  logic                             cfg_wr_en_i,
  input  logic [ism_pkg::NSUB_W-1:0]       cfg_wr_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic [ism_pkg::SUB_W-1:0]        sub_index_i,
  input  logic [ism_pkg::SLOT_W-1:0]       slot_i,
  input  logic [ism_pkg::ATTR_W-1:0]       attribute_i,
  input  logic signed [ism_pkg::VAL_W-1:0] low_value_i,
  input  logic signed [ism_pkg::VAL_W-1:0] high_value_i,
  input  logic signed [ism_pkg::VAL_W-1:0] pair_value_i,
  input  logic                             last_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ism_pkg::NSUB_W-1:0]       match_count_o,
  output logic                             pairs_dropped_o
);

  // Configuration register.
  logic [ism_pkg::NSUB_W-1:0] subs_in_use_q;
  logic [ism_pkg::NSUB_W-1:0] subs_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subs_in_use_q <= '0;
    end else if (cfg_wr_en_i) begin
      subs_in_use_q <= cfg_wr_data_i;
    end
  end

  // Values above the table size examine the whole table.
  assign subs_limit = (subs_in_use_q > ism_pkg::MAX_SUBS_N) ? ism_pkg::MAX_SUBS_N
                                                            : subs_in_use_q;

  // Sequencer state and counters.
  ism_pkg::state_e             state_q, state_d;
  logic [ism_pkg::SUB_W-1:0]   clr_q, clr_d;
  logic [ism_pkg::SUB_W-1:0]   sub_q, sub_d;
  logic [ism_pkg::SLOT_W-1:0]  con_q, con_d;
  logic [ism_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [ism_pkg::HELD_W-1:0]  pidx_q, pidx_d;
  logic [ism_pkg::NSUB_W-1:0]  total_q, total_d;
  logic [ism_pkg::HELD_W-1:0]  pairs_held_q, pairs_held_d;
  logic                        overflow_q, overflow_d;

  logic                        out_valid_q, out_valid_d;
  logic [ism_pkg::NSUB_W-1:0]  match_count_q, match_count_d;
  logic                        pairs_dropped_q, pairs_dropped_d;

  // Memories and pair buffer.
  ism_pkg::constraint_t        con_mem [ism_pkg::MAX_SUBS * ism_pkg::MAX_CONSTRAINTS];
  logic [ism_pkg::CNT_W-1:0]   cnt_mem [ism_pkg::MAX_SUBS];
  ism_pkg::pair_t              pair_buf [ism_pkg::MAX_PAIRS];

  ism_pkg::constraint_t        entry_q;
  logic [ism_pkg::CNT_W-1:0]   cnt_rd_q;

  // Decoded handshake and sequencing conditions.
  logic in_xfer;
  logic load_xfer;
  logic pair_xfer;
  logic pair_room;
  logic clr_done;
  logic last_sub;
  logic last_con;
  logic pairs_exhausted;
  logic out_free;
  logic cmp_hit;
  logic [ism_pkg::CNT_W-1:0] cnt_clamped;

  assign in_xfer   = in_valid_i & ~in_stall_o;
  assign load_xfer = in_xfer & (cmd_i == ism_pkg::CMD_LOAD);
  assign pair_xfer = in_xfer & (cmd_i == ism_pkg::CMD_PAIR);
  assign pair_room = (pairs_held_q < ism_pkg::MAX_PAIRS_N);
  assign clr_done  = (clr_q == ism_pkg::SUB_W'(ism_pkg::MAX_SUBS - 1));
  assign last_sub  = (({1'b0, sub_q} + ism_pkg::NSUB_W'(1)) == subs_limit);
  assign last_con  = (({1'b0, con_q} + ism_pkg::CNT_W'(1)) == cnt_q);
  assign pairs_exhausted = (pidx_q == pairs_held_q);
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign cnt_clamped = (cnt_rd_q > ism_pkg::MAX_CONSTRAINTS_N) ? ism_pkg::MAX_CONSTRAINTS_N
                                                               : cnt_rd_q;

  // The one compare unit, fed by the registered table entry and the pair under scan.
  ism_range_cmp u_cmp (
    .entry_i (entry_q),
    .pair_i  (pair_buf[pidx_q[ism_pkg::PIDX_W-1:0]]),
    .hit_o   (cmp_hit)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ism_pkg::ST_CLEAR: begin
        if (clr_done) state_d = ism_pkg::ST_IDLE;
      end
      ism_pkg::ST_IDLE: begin
        if (pair_xfer && last_i) begin
          state_d = (subs_limit == '0) ? ism_pkg::ST_FINISH : ism_pkg::ST_SUB_RD;
        end
      end
      ism_pkg::ST_SUB_RD: begin
        state_d = ism_pkg::ST_SUB_CHK;
      end
      ism_pkg::ST_SUB_CHK: begin
        if (cnt_clamped != '0) begin
          state_d = ism_pkg::ST_CON_RD;
        end else if (last_sub) begin
          state_d = ism_pkg::ST_FINISH;
        end else begin
          state_d = ism_pkg::ST_SUB_RD;
        end
      end
      ism_pkg::ST_CON_RD: begin
        state_d = ism_pkg::ST_SCAN;
      end
      ism_pkg::ST_SCAN: begin
        if (pairs_exhausted || (cmp_hit && last_con)) begin
          state_d = last_sub ? ism_pkg::ST_FINISH : ism_pkg::ST_SUB_RD;
        end else if (cmp_hit) begin
          state_d = ism_pkg::ST_CON_RD;
        end
      end
      ism_pkg::ST_FINISH: begin
        if (out_free) state_d = ism_pkg::ST_IDLE;
      end
      default: state_d = ism_pkg::ST_CLEAR;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    clr_d           = clr_q;
    sub_d           = sub_q;
    con_d           = con_q;
    cnt_d           = cnt_q;
    pidx_d          = pidx_q;
    total_d         = total_q;
    pairs_held_d    = pairs_held_q;
    overflow_d      = overflow_q;
    out_valid_d     = out_valid_q & out_stall_i;
    match_count_d   = match_count_q;
    pairs_dropped_d = pairs_dropped_q;
    in_stall_o      = 1'b1;

    unique case (state_q)
      ism_pkg::ST_CLEAR: begin
        clr_d = clr_q + ism_pkg::SUB_W'(1);
      end
      ism_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (pair_xfer) begin
          if (pair_room) begin
            pairs_held_d = pairs_held_q + ism_pkg::HELD_W'(1);
          end else begin
            overflow_d = 1'b1;
          end
          if (last_i) begin
            sub_d   = '0;
            total_d = '0;
          end
        end
      end
      ism_pkg::ST_SUB_RD: begin
      end
      ism_pkg::ST_SUB_CHK: begin
        cnt_d = cnt_clamped;
        con_d = '0;
        if (cnt_clamped == '0) begin
          // A subscription without constraints matches any publication.
          total_d = total_q + ism_pkg::NSUB_W'(1);
          if (!last_sub) sub_d = sub_q + ism_pkg::SUB_W'(1);
        end
      end
      ism_pkg::ST_CON_RD: begin
        pidx_d = '0;
      end
      ism_pkg::ST_SCAN: begin
        if (pairs_exhausted) begin
          if (!last_sub) sub_d = sub_q + ism_pkg::SUB_W'(1);
        end else if (cmp_hit) begin
          if (last_con) begin
            total_d = total_q + ism_pkg::NSUB_W'(1);
            if (!last_sub) sub_d = sub_q + ism_pkg::SUB_W'(1);
          end else begin
            con_d = con_q + ism_pkg::SLOT_W'(1);
          end
        end else begin
          pidx_d = pidx_q + ism_pkg::HELD_W'(1);
        end
      end
      ism_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          match_count_d   = total_q;
          pairs_dropped_d = overflow_q;
          pairs_held_d    = '0;
          overflow_d      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ism_pkg::ST_CLEAR;
      clr_q        <= '0;
      sub_q        <= '0;
      con_q        <= '0;
      cnt_q        <= '0;
      pidx_q       <= '0;
      total_q      <= '0;
      pairs_held_q <= '0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      sub_q        <= sub_d;
      con_q        <= con_d;
      cnt_q        <= cnt_d;
      pidx_q       <= pidx_d;
      total_q      <= total_d;
      pairs_held_q <= pairs_held_d;
      overflow_q   <= overflow_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload holds while a transfer is pending.
  always_ff @(posedge clk_i) begin
    match_count_q   <= match_count_d;
    pairs_dropped_q <= pairs_dropped_d;
  end

  assign out_valid_o     = out_valid_q;
  assign match_count_o   = match_count_q;
  assign pairs_dropped_o = pairs_dropped_q;

  // Pair buffer: written at the fill position while there is room.
  always_ff @(posedge clk_i) begin
    if (pair_xfer && pair_room) begin
      pair_buf[pairs_held_q[ism_pkg::PIDX_W-1:0]] <= '{attribute: attribute_i,
                                                       value:     pair_value_i};
    end
  end

  // Constraint table: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (load_xfer) begin
      con_mem[{sub_index_i, slot_i}] <= '{attribute:  attribute_i,
                                          low_value:  low_value_i,
                                          high_value: high_value_i};
    end
    if (state_q == ism_pkg::ST_CON_RD) begin
      entry_q <= con_mem[{sub_q, con_q}];
    end
  end

  // Constraint count table: cleared after reset, then written by final loads.
  logic                      cnt_we;
  logic [ism_pkg::SUB_W-1:0] cnt_waddr;
  logic [ism_pkg::CNT_W-1:0] cnt_wdata;

  always_comb begin
    if (state_q == ism_pkg::ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
    end else begin
      cnt_we    = load_xfer & last_i;
      cnt_waddr = sub_index_i;
      cnt_wdata = {1'b0, slot_i} + ism_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (state_q == ism_pkg::ST_SUB_RD) begin
      cnt_rd_q <= cnt_mem[sub_q];
    end
  end

  // Checks on the sequencer.
  a_held_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pairs_held_q <= ism_pkg::MAX_PAIRS_N)
    else $error("pair buffer fill beyond its depth");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ism_pkg::ST_SCAN) |-> (total_q <= {1'b0, sub_q}))
    else $error("match total exceeds subscriptions examined");

  a_con_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ism_pkg::ST_SCAN) |-> ({1'b0, con_q} < cnt_q))
    else $error("constraint index beyond subscription count");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ism_pkg::ST_FINISH) && out_free
      |=> out_valid_q && (state_q == ism_pkg::ST_IDLE) && (pairs_held_q == '0))
    else $error("finished match did not load the result register");

endmodule

`default_nettype wire

// ----- dv/tb_interval_subscription_matcher_top.sv -----
// Self-checking testbench of the interval subscription matcher with a match-count scoreboard.
`default_nettype none

module tb_interval_subscription_matcher_top;

  // Directed extremes of the signed 32-bit value fields.
  localparam logic signed [ism_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ism_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Random stimulus is split into phases, each with its own subscriptions_in_use.
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_ITEMS = 130;

  // Loads never start a match, so the block is idle once the last result is back.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // The slowest match walks every slot with a full constraint list against a full
  // pair buffer. The watchdog allows that, the clearing pass after reset, the
  // long receiver hold-off and the longest sender gap, three times over.
  localparam int unsigned WORST_MATCH =
      ism_pkg::MAX_SUBS * (2 + ism_pkg::MAX_CONSTRAINTS * (2 + ism_pkg::MAX_PAIRS)) + 1;
  localparam int unsigned WATCHDOG_LIMIT =
      3 * (WORST_MATCH + ism_pkg::MAX_SUBS + HOLD_OFF_CYCLES + 100);

  // One input transfer as seen on the item ports.
  typedef struct {
    ism_pkg::cmd_e                     cmd;
    logic [ism_pkg::SUB_W-1:0]         sub_index;
    logic [ism_pkg::SLOT_W-1:0]        slot;
    logic [ism_pkg::ATTR_W-1:0]        attribute;
    logic signed [ism_pkg::VAL_W-1:0]  low_value;
    logic signed [ism_pkg::VAL_W-1:0]  high_value;
    logic signed [ism_pkg::VAL_W-1:0]  pair_value;
    logic                              last;
  } item_t;

  // One result transfer.
  typedef struct {
    logic [ism_pkg::NSUB_W-1:0] match_count;
    logic                       pairs_dropped;
  } tally_t;

  // The scoreboard keeps its own copy of the subscription table and of the pair
  // buffer. Every accepted pair flagged last produces one expected tally, which is
  // queued until the block delivers its result transfer.
  class match_count_board;
    ism_pkg::constraint_t con_table [ism_pkg::MAX_SUBS * ism_pkg::MAX_CONSTRAINTS];
    int unsigned          con_count [ism_pkg::MAX_SUBS];
    ism_pkg::pair_t       pair_buf [ism_pkg::MAX_PAIRS];
    int unsigned          held;
    bit                   overflow;
    int unsigned          subs_in_use;
    tally_t               expected_tallies [$];
    int unsigned          error_count;

    function new();
      foreach (con_count[s]) con_count[s] = 0;
      held = 0;
      overflow = 1'b0;
      subs_in_use = 0;
      error_count = 0;
    endfunction

    function void set_subs_in_use(logic [ism_pkg::NSUB_W-1:0] value);
      subs_in_use = value;
    endfunction

    function int unsigned waiting();
      return expected_tallies.size();
    endfunction

    // Counts the examined slots whose every constraint is met by some held pair.
    function int unsigned count_matching_subs();
      int unsigned limit;
      int unsigned total;
      int unsigned e;
      bit ok;
      bit hit;
      limit = (subs_in_use > ism_pkg::MAX_SUBS) ? ism_pkg::MAX_SUBS : subs_in_use;
      total = 0;
      for (int unsigned s = 0; s < limit; s++) begin
        ok = 1'b1;
        for (int unsigned j = 0; ok && j < con_count[s]; j++) begin
          e = s * ism_pkg::MAX_CONSTRAINTS + j;
          hit = 1'b0;
          for (int unsigned k = 0; k < held; k++) begin
            if (pair_buf[k].attribute == con_table[e].attribute &&
                $signed(pair_buf[k].value) >= $signed(con_table[e].low_value) &&
                $signed(pair_buf[k].value) <= $signed(con_table[e].high_value))
              hit = 1'b1;
          end
          ok = hit;
        end
        if (ok) total++;
      end
      return total;
    endfunction

    function void record_item(item_t it);
      int unsigned e;
      tally_t t;
      if (it.cmd == ism_pkg::CMD_LOAD) begin
        e = it.sub_index * ism_pkg::MAX_CONSTRAINTS + it.slot;
        con_table[e].attribute  = it.attribute;
        con_table[e].low_value  = it.low_value;
        con_table[e].high_value = it.high_value;
        if (it.last) con_count[it.sub_index] = it.slot + 1;
        return;
      end
      // A full buffer drops the pair, including one that closes the publication.
      if (held < ism_pkg::MAX_PAIRS) begin
        pair_buf[held].attribute = it.attribute;
        pair_buf[held].value     = it.pair_value;
        held++;
      end else begin
        overflow = 1'b1;
      end
      if (!it.last) return;
      t.match_count   = ism_pkg::NSUB_W'(count_matching_subs());
      t.pairs_dropped = overflow;
      expected_tallies.insert(expected_tallies.size(), t);
      held = 0;
      overflow = 1'b0;
    endfunction

    function void compare_tally(logic [ism_pkg::NSUB_W-1:0] count, logic dropped);
      tally_t t;
      if (expected_tallies.size() == 0) begin
        $error("result transfer with no publication pending: match_count=%0d pairs_dropped=%0d",
               count, dropped);
        error_count++;
        return;
      end
      t = expected_tallies.pop_front();
      if (count !== t.match_count) begin
        $error("match_count: expected %0d, actual %0d", t.match_count, count);
        error_count++;
      end
      if (dropped !== t.pairs_dropped) begin
        $error("pairs_dropped: expected %0d, actual %0d", t.pairs_dropped, dropped);
        error_count++;
      end
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic                             clk_i = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [ism_pkg::NSUB_W-1:0]       cfg_wr_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  ism_pkg::cmd_e                    cmd = ism_pkg::CMD_LOAD;
  logic [ism_pkg::SUB_W-1:0]        sub_index = '0;
  logic [ism_pkg::SLOT_W-1:0]       slot = '0;
  logic [ism_pkg::ATTR_W-1:0]       attribute = '0;
  logic signed [ism_pkg::VAL_W-1:0] low_value = '0;
  logic signed [ism_pkg::VAL_W-1:0] high_value = '0;
  logic signed [ism_pkg::VAL_W-1:0] pair_value = '0;
  logic                             last = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [ism_pkg::NSUB_W-1:0]       match_count;
  logic                             pairs_dropped;

  match_count_board board;

  // Slots loaded so far. A load flagged last is only sent when every slot below it
  // has been written, so a match never reads a table entry that holds no value.
  bit          slot_written [ism_pkg::MAX_SUBS][ism_pkg::MAX_CONSTRAINTS];
  int unsigned items_sent = 0;
  bit          send_calm = 1'b0;    // sender runs without gaps while set
  bit          hold_off_req = 1'b0; // asks the result side for one long stall

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  interval_subscription_matcher_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .sub_index_i     (sub_index),
    .slot_i          (slot),
    .attribute_i     (attribute),
    .low_value_i     (low_value),
    .high_value_i    (high_value),
    .pair_value_i    (pair_value),
    .last_i          (last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .match_count_o   (match_count),
    .pairs_dropped_o (pairs_dropped)
  );

  // Idle stretch length: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Attributes cluster on a few ids so that constraints and pairs meet often.
  function automatic logic [ism_pkg::ATTR_W-1:0] pick_attr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return ism_pkg::ATTR_W'($urandom_range(0, 5));
    if (r < 90) return ism_pkg::ATTR_W'($urandom_range(250, 255));
    return ism_pkg::ATTR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [ism_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return int'($urandom_range(0, 16)) - 8;
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // Upper bound of an interval: mostly a narrow window above the lower bound, which
  // may wrap near the top of the range and so give an empty interval.
  function automatic logic signed [ism_pkg::VAL_W-1:0] pick_high(
      logic signed [ism_pkg::VAL_W-1:0] lo);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return lo + $urandom_range(0, 12);
    if (r < 90) return pick_value();
    return VAL_MAX;
  endfunction

  // All fields random; the fields that a command does not use stay random too.
  function automatic item_t random_item();
    item_t it;
    it.cmd        = ism_pkg::cmd_e'($urandom_range(0, 1));
    it.sub_index  = ism_pkg::SUB_W'($urandom_range(0, ism_pkg::MAX_SUBS - 1));
    it.slot       = ism_pkg::SLOT_W'($urandom_range(0, ism_pkg::MAX_CONSTRAINTS - 1));
    it.attribute  = ism_pkg::ATTR_W'($urandom_range(0, 255));
    it.low_value  = $urandom;
    it.high_value = $urandom;
    it.pair_value = $urandom;
    it.last       = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic item_t make_load(int unsigned sub_id, int unsigned pos,
                                      int unsigned attr,
                                      logic signed [ism_pkg::VAL_W-1:0] lo,
                                      logic signed [ism_pkg::VAL_W-1:0] hi, logic fin);
    item_t it;
    it = random_item();
    it.cmd        = ism_pkg::CMD_LOAD;
    it.sub_index  = ism_pkg::SUB_W'(sub_id);
    it.slot       = ism_pkg::SLOT_W'(pos);
    it.attribute  = ism_pkg::ATTR_W'(attr);
    it.low_value  = lo;
    it.high_value = hi;
    it.last       = fin;
    return it;
  endfunction

  function automatic item_t make_pair(int unsigned attr,
                                      logic signed [ism_pkg::VAL_W-1:0] val, logic fin);
    item_t it;
    it = random_item();
    it.cmd        = ism_pkg::CMD_PAIR;
    it.attribute  = ism_pkg::ATTR_W'(attr);
    it.pair_value = val;
    it.last       = fin;
    return it;
  endfunction

  // Stray traffic: a random constraint write to any slot, or a lone pair that
  // joins whatever publication comes next.
  function automatic item_t noise_item();
    item_t it;
    bit    ready;
    it = random_item();
    if (it.cmd == ism_pkg::CMD_PAIR) begin
      it.last = 1'b0;
      return it;
    end
    ready = 1'b1;
    for (int unsigned p = 0; p <= it.slot; p++)
      if (!slot_written[it.sub_index][p]) ready = 1'b0;
    if (!ready) it.last = 1'b0;
    return it;
  endfunction

  // Offers one item and returns at the edge where it is transferred. Valid stays
  // high afterwards, so a caller that follows with another item at once keeps a
  // back-to-back stream; anything that lets time pass lowers valid first.
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    cmd        <= it.cmd;
    sub_index  <= it.sub_index;
    slot       <= it.slot;
    attribute  <= it.attribute;
    low_value  <= it.low_value;
    high_value <= it.high_value;
    pair_value <= it.pair_value;
    last       <= it.last;
    do @(posedge clk_i); while (in_stall);
    board.record_item(it);
    if (it.cmd == ism_pkg::CMD_LOAD) slot_written[it.sub_index][it.slot] = 1'b1;
    items_sent++;
  endtask

  // A well-formed subscription: slots written in order, the final one flagged last.
  // Now and then the sequence is cut off before its last load, which leaves the
  // stored constraint count as it was.
  task automatic load_subscription();
    int unsigned                      sub_id;
    int unsigned                      n;
    logic signed [ism_pkg::VAL_W-1:0] lo;
    sub_id = ($urandom_range(0, 99) < 85)
           ? $urandom_range(0, 47)
           : $urandom_range(ism_pkg::MAX_SUBS - 8, ism_pkg::MAX_SUBS - 1);
    n = ($urandom_range(0, 99) < 60) ? $urandom_range(1, 3)
                                     : $urandom_range(4, ism_pkg::MAX_CONSTRAINTS);
    for (int unsigned p = 0; p < n; p++) begin
      if (p == n - 1 && p != 0 && $urandom_range(0, 9) == 0) break;
      lo = ($urandom_range(0, 19) == 0) ? VAL_MIN : pick_value();
      send_item(make_load(sub_id, p, pick_attr(), lo, pick_high(lo), p == n - 1));
    end
  endtask

  // A publication of a few pairs, sometimes long enough to overflow the buffer.
  task automatic send_publication();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(1, 6);
    else if (r < 90) n = $urandom_range(7, ism_pkg::MAX_PAIRS);
    else n = $urandom_range(ism_pkg::MAX_PAIRS + 1, ism_pkg::MAX_PAIRS + 4);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) send_item(noise_item());
      send_item(make_pair(pick_attr(), pick_value(), i == n - 1));
    end
  endtask

  // While the result side holds off, short publications keep coming. The first
  // tally parks in the output register, the next match has to wait for it, and
  // the input side backs up behind that match.
  task automatic crowd_output();
    send_calm = 1'b1;
    hold_off_req = 1'b1;
    repeat (4) send_item(make_pair(pick_attr(), pick_value(), 1'b1));
    send_calm = 1'b0;
  endtask

  // The register is written only when the block is idle: every tally has come
  // back and any trailing loads have had time to retire.
  task automatic settle_and_configure(input int unsigned value);
    in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ism_pkg::NSUB_W'(value);
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    board.set_subs_in_use(ism_pkg::NSUB_W'(value));
  endtask

  // Result side: checks each result transfer and drives stall. Stall comes in
  // random stretches, with calm spans of no stall and one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) board.compare_tally(match_count, pairs_dropped);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
        if (calm_left != 0) calm_left--;
        else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(30, 150);
        else stall_left = pick_gap(1'b0);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_interval_subscription_matcher_top: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_setting [PHASE_COUNT];
    int unsigned phase_end;
    int unsigned r;
    board = new();
    // Includes zero, a single slot, the full table and an oversized value that
    // the block saturates to the table size.
    phase_setting = '{48, 2047, 13, 0, ism_pkg::MAX_SUBS, 1, 64, 30};
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part with five slots examined.
    settle_and_configure(5);
    // Slot 0 takes the widest interval, slot 1 needs two attributes, slot 2 has an
    // empty interval, slot 3 stays without constraints and matches anything, and
    // slot 4 accepts only the largest value.
    send_item(make_load(0, 0, 0, VAL_MIN, VAL_MAX, 1'b1));
    send_item(make_load(1, 0, 255, -5, 5, 1'b0));
    send_item(make_load(1, 1, 1, 10, 10, 1'b1));
    send_item(make_load(2, 0, 0, 7, 3, 1'b1));
    send_item(make_load(4, 0, 2, VAL_MAX, VAL_MAX, 1'b1));
    // Highest slot and position, written without closing the subscription.
    send_item(make_load(ism_pkg::MAX_SUBS - 1, ism_pkg::MAX_CONSTRAINTS - 1, 128, -1, 0,
                        1'b0));
    send_item(make_pair(0, VAL_MIN, 1'b0));
    send_item(make_pair(255, 5, 1'b0));
    send_item(make_pair(2, VAL_MAX, 1'b0));
    send_item(make_pair(1, 10, 1'b1));
    // One pair more than the buffer holds; the closing pair itself is dropped.
    for (int unsigned i = 0; i <= ism_pkg::MAX_PAIRS; i++)
      send_item(make_pair((i == 0) ? 1 : 3, (i == 0) ? 11 : i, i == ism_pkg::MAX_PAIRS));

    // Random part, one phase per register setting.
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      settle_and_configure(phase_setting[ph]);
      if (ph == 0 || ph == 4) crowd_output();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        r = $urandom_range(0, 99);
        if (r < 45) send_publication();
        else if (r < 85) load_subscription();
        else send_item(noise_item());
      end
      send_calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.error_count == 0 && board.waiting() == 0)
      $display("tb_interval_subscription_matcher_top: clean");
    else
      $display("tb_interval_subscription_matcher_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
